// ===== hdl/sepe_pkg.sv =====
// Shared types and constants for the soft-edge ellipse pixel evaluator.
// No dependencies; compiled first.
`default_nettype none
package sepe_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_BOX_WIDTH  = 3'd2,
    REG_BOX_HEIGHT = 3'd3,
    REG_PEAK_ALPHA = 3'd4,
    REG_BLUR       = 3'd5,
    REG_FILL_COLOR = 3'd6
  } reg_idx_t;

  localparam int CfgDataW = 24;
  localparam int CoordW   = 17;
  localparam int OffW     = 11;
  localparam int DimW     = 12;
  localparam int AlphaW   = 8;
  localparam int BlurW    = 9;

  // Live configuration seen by the pipeline
  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [DimW-1:0]    box_width;
    logic [DimW-1:0]    box_height;
    logic [AlphaW-1:0]  peak_alpha;
    logic [BlurW-1:0]   blur_fraction;
  } cfg_t;

  // Sideband carried alongside the arithmetic
  typedef struct packed {
    logic              hit;
    logic              solid;
    logic [CoordW-1:0] lx;
    logic [CoordW-1:0] rx;
    logic [CoordW-1:0] ty;
    logic [CoordW-1:0] by;
    logic [AlphaW-1:0] peak;
  } side_t;

endpackage
`default_nettype wire

// ===== hdl/sepe_if.sv =====
// Valid/ready channel interfaces for the ellipse evaluator.
// Depends on nothing but plain logic types.
`default_nettype none
interface sepe_in_if;
  logic        valid;
  logic        ready;
  logic [10:0] column_offset;
  logic [10:0] row_offset;
  modport source (output valid, column_offset, row_offset, input ready);
  modport sink   (input valid, column_offset, row_offset, output ready);
endinterface

interface sepe_out_if;
  logic               valid;
  logic               ready;
  logic               inside_res;
  logic signed [16:0] left_x;
  logic signed [16:0] right_x;
  logic signed [16:0] top_y;
  logic signed [16:0] bottom_y;
  logic [7:0]         pixel_alpha;
  modport source (output valid, inside_res, left_x, right_x, top_y, bottom_y, pixel_alpha,
                  input ready);
  modport sink   (input valid, inside_res, left_x, right_x, top_y, bottom_y, pixel_alpha,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/sepe_front.sv =====
// Front five pipeline stages: squares, products, ellipse test, fade numerator.
// Depends on sepe_pkg.
`default_nettype none
module sepe_front import sepe_pkg::*; #(
  parameter int DIM_BITS = 12
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire cfg_t           cfg,
  input  wire logic           in_valid,
  input  wire logic [OffW-1:0] cx,
  input  wire logic [OffW-1:0] cy,
  output logic                o_valid,
  output logic [4*((DIM_BITS < 12) ? DIM_BITS : 12)-4+8-1:0] o_p,
  output logic [4*((DIM_BITS < 12) ? DIM_BITS : 12)-4-1:0]   o_d,
  output side_t               o_side
);
  localparam int WB = (DIM_BITS < 12) ? DIM_BITS : 12;
  localparam int HB = WB - 1;
  localparam int SW = 2 * HB;
  localparam int TW = 4 * HB;
  localparam int PW = TW + 8;

  logic [HB-1:0] hw, hh;
  logic          oor;
  logic [BlurW-1:0] keep;
  assign hw   = cfg.box_width[WB-1:1];
  assign hh   = cfg.box_height[WB-1:1];
  assign oor  = (cx >= OffW'(hw)) || (cy >= OffW'(hh));
  assign keep = cfg.blur_fraction[8] ? '0 : BlurW'(9'd256 - cfg.blur_fraction);

  // Stage 1: squares and mirrored coordinates
  logic          v1_r;
  logic          oor1_r;
  logic [SW-1:0] cx2_r, cy2_r, ww_r, h2_r;
  side_t         s1_r;
  logic [CoordW-1:0] ox, oy;
  assign ox = {cfg.origin_x[15], cfg.origin_x};
  assign oy = {cfg.origin_y[15], cfg.origin_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      oor1_r   <= oor;
      cx2_r    <= cx[HB-1:0] * cx[HB-1:0];
      cy2_r    <= cy[HB-1:0] * cy[HB-1:0];
      ww_r     <= hw * hw;
      h2_r     <= hh * hh;
      s1_r.hit   <= 1'b0;
      s1_r.solid <= 1'b0;
      s1_r.lx  <= ox + CoordW'(hw) - CoordW'(1) - CoordW'(cx);
      s1_r.rx  <= ox + CoordW'(cfg.box_width) - CoordW'(hw) + CoordW'(cx);
      s1_r.ty  <= oy + CoordW'(hh) - CoordW'(1) - CoordW'(cy);
      s1_r.by  <= oy + CoordW'(cfg.box_height) - CoordW'(hh) + CoordW'(cy);
      s1_r.peak <= cfg.peak_alpha;
    end
  end

  // Stage 2: cross products and total
  logic          v2_r, oor2_r;
  logic [TW-1:0] a2_r, b2_r, t2_r;
  side_t         s2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      oor2_r <= oor1_r;
      a2_r   <= cx2_r * h2_r;
      b2_r   <= cy2_r * ww_r;
      t2_r   <= ww_r * h2_r;
      s2_r   <= s1_r;
    end
  end

  // Stage 3: distance sum and inner bound
  logic            v3_r, oor3_r;
  logic [TW:0]     vv3_r;
  logic [TW-1:0]   t3_r, n3_r;
  side_t           s3_r;
  logic [TW+BlurW-9:0] nq;
  logic [17:0]     nr;
  assign nq = t2_r[TW-1:8] * keep;
  assign nr = 18'(t2_r[7:0]) * 18'(keep) + 18'd128;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      oor3_r <= oor2_r;
      vv3_r  <= (TW+1)'(a2_r) + (TW+1)'(b2_r);
      t3_r   <= t2_r;
      n3_r   <= TW'(nq) + TW'(nr[17:8]);
      s3_r   <= s2_r;
    end
  end

  // Stage 4: inside test, fade numerator and denominator
  logic          v4_r;
  logic [TW-1:0] n4_r, d4_r;
  side_t         s4_r;
  side_t         s4_nxt;
  always_comb begin
    s4_nxt       = s3_r;
    s4_nxt.hit   = !oor3_r && (vv3_r <= (TW+1)'(t3_r));
    s4_nxt.solid = vv3_r <= (TW+1)'(n3_r);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_r <= s4_nxt;
      n4_r <= t3_r - vv3_r[TW-1:0];
      d4_r <= t3_r - n3_r;
    end
  end

  // Stage 5: scale numerator by peak alpha
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= v4_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      o_p    <= PW'(n4_r) * PW'(s4_r.peak);
      o_d    <= d4_r;
      o_side <= s4_r;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/sepe_divider.sv =====
// Eight-stage restoring divider: one quotient bit per stage, remainder kept.
// Depends on sepe_pkg.
`default_nettype none
module sepe_divider import sepe_pkg::*; #(
  parameter int TW = 44
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire logic           i_valid,
  input  wire logic [TW+7:0]  i_p,
  input  wire logic [TW-1:0]  i_d,
  input  wire side_t          i_side,
  output logic                o_valid,
  output logic [AlphaW-1:0]   o_q,
  output logic [TW+7:0]       o_rem,
  output logic [TW-1:0]       o_d,
  output side_t               o_side
);
  localparam int PW = TW + 8;

  logic              v_r   [0:AlphaW];
  logic [PW-1:0]     rem_r [0:AlphaW];
  logic [TW-1:0]     d_r   [0:AlphaW];
  logic [AlphaW-1:0] q_r   [0:AlphaW];
  side_t             s_r   [0:AlphaW];

  assign v_r[0]   = i_valid;
  assign rem_r[0] = i_p;
  assign d_r[0]   = i_d;
  assign q_r[0]   = '0;
  assign s_r[0]   = i_side;

  for (genvar k = 0; k < AlphaW; k++) begin : g_stage
    localparam int Sh = AlphaW - 1 - k;
    logic [PW-1:0] dsh;
    logic          take;
    assign dsh  = PW'(d_r[k]) << Sh;
    assign take = rem_r[k] >= dsh;

    // Hold valid under stall, advance otherwise
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end
    // Decide one quotient bit
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1]     <= take ? rem_r[k] - dsh : rem_r[k];
        q_r[k+1]       <= q_r[k] | (AlphaW'(take) << Sh);
        d_r[k+1]       <= d_r[k];
        s_r[k+1]       <= s_r[k];
      end
    end
  end

  assign o_valid = v_r[AlphaW];
  assign o_q     = q_r[AlphaW];
  assign o_rem   = rem_r[AlphaW];
  assign o_d     = d_r[AlphaW];
  assign o_side  = s_r[AlphaW];
endmodule
`default_nettype wire

// ===== hdl/soft_edge_ellipse_pixel_eval.sv =====
// Soft-edge filled ellipse evaluator, top level.
// Depends on sepe_pkg, sepe_if, sepe_front and sepe_divider.
//
// Usage:
//   Write the box origin, size, peak alpha, blur and fill color through the
//   cfg_ port (cfg_we, cfg_index, cfg_wdata) while no transaction is in flight.
//   Each in_ch transaction carries a column and row offset from the box center;
//   each out_ch transaction returns the inside flag, the four mirrored pixel
//   coordinates and the alpha, in input order. Cells outside the ellipse or at
//   or past a half axis return inside_res = 0 with all other fields zero.
// Timing:
//   Fourteen register stages: five arithmetic stages, eight divider stages
//   (one alpha bit each) and the rounding/output register. Throughput is one
//   transaction per cycle while out_ch does not stall; the whole pipeline
//   advances as one.
// Reset:
//   rst_n clears all valid bits and loads the register reset values
//   (peak alpha 255, everything else zero).
// Stall:
//   When out_ch.ready is low with a result waiting, the pipeline holds and
//   in_ch.ready drops in the same cycle; nothing is dropped or repeated.
`default_nettype none
module soft_edge_ellipse_pixel_eval import sepe_pkg::*; #(
  parameter int DIM_BITS = 12
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  sepe_in_if.sink                  in_ch,
  sepe_out_if.source               out_ch,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);
  localparam int WB = (DIM_BITS < 12) ? DIM_BITS : 12;
  localparam int HB = WB - 1;
  localparam int TW = 4 * HB;
  localparam int PW = TW + 8;
  localparam logic [DimW-1:0] DMask = DimW'((1 << WB) - 1);

  // Configuration registers
  logic signed [15:0] origin_x_r, origin_y_r;
  logic [DimW-1:0]    box_width_r, box_height_r;
  logic [AlphaW-1:0]  peak_alpha_r;
  logic [BlurW-1:0]   blur_fraction_r;
  logic [23:0]        fill_color_r;
  cfg_t               cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r      <= '0;
      origin_y_r      <= '0;
      box_width_r     <= '0;
      box_height_r    <= '0;
      peak_alpha_r    <= 8'd255;
      blur_fraction_r <= '0;
      fill_color_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X:   origin_x_r      <= cfg_wdata[15:0];
        REG_ORIGIN_Y:   origin_y_r      <= cfg_wdata[15:0];
        REG_BOX_WIDTH:  box_width_r     <= cfg_wdata[DimW-1:0] & DMask;
        REG_BOX_HEIGHT: box_height_r    <= cfg_wdata[DimW-1:0] & DMask;
        REG_PEAK_ALPHA: peak_alpha_r    <= cfg_wdata[AlphaW-1:0];
        REG_BLUR:       blur_fraction_r <= cfg_wdata[BlurW-1:0];
        REG_FILL_COLOR: fill_color_r    <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  assign cfg.origin_x      = origin_x_r;
  assign cfg.origin_y      = origin_y_r;
  assign cfg.box_width     = box_width_r;
  assign cfg.box_height    = box_height_r;
  assign cfg.peak_alpha    = peak_alpha_r;
  assign cfg.blur_fraction = blur_fraction_r;

  // Global advance: move when the output slot is free or being taken
  logic adv;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  logic          f_valid;
  logic [PW-1:0] f_p;
  logic [TW-1:0] f_d;
  side_t         f_side;

  sepe_front #(.DIM_BITS(DIM_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .cfg      (cfg),
    .in_valid (in_ch.valid),
    .cx       (in_ch.column_offset),
    .cy       (in_ch.row_offset),
    .o_valid  (f_valid),
    .o_p      (f_p),
    .o_d      (f_d),
    .o_side   (f_side)
  );

  logic              dv_valid;
  logic [AlphaW-1:0] dv_q;
  logic [PW-1:0]     dv_rem;
  logic [TW-1:0]     dv_d;
  side_t             dv_side;

  sepe_divider #(.TW(TW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .i_valid (f_valid),
    .i_p     (f_p),
    .i_d     (f_d),
    .i_side  (f_side),
    .o_valid (dv_valid),
    .o_q     (dv_q),
    .o_rem   (dv_rem),
    .o_d     (dv_d),
    .o_side  (dv_side)
  );

  // Round half up, pick solid alpha, zero cells outside
  logic              rnd_up;
  logic [AlphaW-1:0] alpha_nxt;
  logic              ins;
  assign rnd_up    = {dv_rem, 1'b0} >= (PW+1)'(dv_d);
  assign alpha_nxt = dv_side.solid ? dv_side.peak : AlphaW'(dv_q + AlphaW'(rnd_up));
  assign ins       = dv_side.hit;

  logic              out_valid_r;
  logic              inside_r;
  logic [CoordW-1:0] lx_r, rx_r, ty_r, by_r;
  logic [AlphaW-1:0] alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      inside_r <= ins;
      lx_r     <= ins ? dv_side.lx : '0;
      rx_r     <= ins ? dv_side.rx : '0;
      ty_r     <= ins ? dv_side.ty : '0;
      by_r     <= ins ? dv_side.by : '0;
      alpha_r  <= ins ? alpha_nxt : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.inside_res  = inside_r;
  assign out_ch.left_x      = lx_r;
  assign out_ch.right_x     = rx_r;
  assign out_ch.top_y       = ty_r;
  assign out_ch.bottom_y    = by_r;
  assign out_ch.pixel_alpha = alpha_r;

  // Outside cells carry no coordinates and no alpha
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.inside_res) |->
      (out_ch.pixel_alpha == '0 && out_ch.left_x == '0 && out_ch.bottom_y == '0))
    else $error("outside cell with nonzero fields");

  // Alpha never exceeds the peak value
  a_alpha_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.pixel_alpha <= peak_alpha_r))
    else $error("alpha above peak");

  // A held result keeps the whole pipeline frozen
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> ($stable(dv_valid) && $stable(f_valid)))
    else $error("pipeline moved during stall");

  // Input is taken exactly when the output slot can move
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("input ready out of step with output");
endmodule
`default_nettype wire

// ===== sim/tb_soft_edge_ellipse_pixel_eval.sv =====
// Self-checking testbench for the soft-edge ellipse pixel evaluator.
// Depends on sepe_pkg, sepe_if and the soft_edge_ellipse_pixel_eval top level.
`default_nettype none
module tb_soft_edge_ellipse_pixel_eval;
  import sepe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic              hit;
    logic [CoordW-1:0] lx;
    logic [CoordW-1:0] rx;
    logic [CoordW-1:0] ty;
    logic [CoordW-1:0] by;
    logic [AlphaW-1:0] alpha;
  } cell_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  sepe_in_if  in_ch();
  sepe_out_if out_ch();

  soft_edge_ellipse_pixel_eval #(.DIM_BITS(12)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the register file
  logic signed [15:0] sh_ox, sh_oy;
  logic [11:0] sh_w, sh_h;
  logic [7:0]  sh_peak;
  logic [8:0]  sh_blur;
  logic [23:0] sh_color;

  cell_t pending_cells[$];
  int err_count;
  int send_idle_pct;
  int recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Expected cell for given offsets under the shadow configuration
  function automatic cell_t eval_cell(logic [10:0] cx, logic [10:0] cy);
    cell_t c;
    logic [63:0] hw, hh, t, v, nb, keep, num, den, q, r;
    logic signed [31:0] sx;
    c = '{default: '0};
    hw = sh_w >> 1;
    hh = sh_h >> 1;
    if (cx >= hw || cy >= hh) return c;
    t = hh * hh * hw * hw;
    v = cx * cx * hh * hh + cy * cy * hw * hw;
    if (v > t) return c;
    keep = 256 - ((sh_blur > 256) ? 256 : sh_blur);
    nb = (t >> 8) * keep + (((t & 64'hFF) * keep + 128) >> 8);
    if (v <= nb) begin
      c.alpha = sh_peak;
    end else begin
      num = (t - v) * sh_peak;
      den = t - nb;
      q = num / den;
      r = num % den;
      if (r >= den - r) q = q + 1;
      c.alpha = q[7:0];
    end
    c.hit = 1'b1;
    sx = sh_ox + $signed(32'(hw - 1 - cx));
    c.lx = sx[16:0];
    sx = sh_ox + $signed(32'(sh_w - hw + cx));
    c.rx = sx[16:0];
    sx = sh_oy + $signed(32'(hh - 1 - cy));
    c.ty = sx[16:0];
    sx = sh_oy + $signed(32'(sh_h - hh + cy));
    c.by = sx[16:0];
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    err_count++;
  endtask

  // Receiver: random stall, compare each transaction against the oldest expectation
  always @(posedge clk) begin
    cell_t w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_cells.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          w = pending_cells.pop_front();
          if (out_ch.inside_res !== w.hit) report_mismatch("inside", out_ch.inside_res, w.hit);
          if (out_ch.left_x !== w.lx) report_mismatch("left_x", out_ch.left_x, w.lx);
          if (out_ch.right_x !== w.rx) report_mismatch("right_x", out_ch.right_x, w.rx);
          if (out_ch.top_y !== w.ty) report_mismatch("top_y", out_ch.top_y, w.ty);
          if (out_ch.bottom_y !== w.by) report_mismatch("bottom_y", out_ch.bottom_y, w.by);
          if (out_ch.pixel_alpha !== w.alpha)
            report_mismatch("alpha", out_ch.pixel_alpha, w.alpha);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Send one cell; expectation is queued at acceptance
  task automatic send_cell(logic [10:0] cx, logic [10:0] cy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.column_offset <= cx;
    in_ch.row_offset <= cy;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_cells.push_back(eval_cell(cx, cy));
  endtask

  // Release valid and wait for every expected result, then for pipeline drain
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Drive one register write; the caller drops the write enable afterwards
  task automatic write_reg(reg_idx_t idx, logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_ORIGIN_X:   sh_ox = val[15:0];
      REG_ORIGIN_Y:   sh_oy = val[15:0];
      REG_BOX_WIDTH:  sh_w = val[11:0];
      REG_BOX_HEIGHT: sh_h = val[11:0];
      REG_PEAK_ALPHA: sh_peak = val[7:0];
      REG_BLUR:       sh_blur = val[8:0];
      REG_FILL_COLOR: sh_color = val[23:0];
      default: ;
    endcase
  endtask

  task automatic set_box(int ox, int oy, int w, int h, int pk, int bl, int col);
    drain();
    write_reg(REG_ORIGIN_X, 24'(ox));
    write_reg(REG_ORIGIN_Y, 24'(oy));
    write_reg(REG_BOX_WIDTH, 24'(w));
    write_reg(REG_BOX_HEIGHT, 24'(h));
    write_reg(REG_PEAK_ALPHA, 24'(pk));
    write_reg(REG_BLUR, 24'(bl));
    write_reg(REG_FILL_COLOR, 24'(col));
    cfg_we <= 1'b0;
  endtask

  // Reset values, degenerate boxes and half-axis limits
  task automatic test_directed();
    send_cell(0, 0);
    set_box(-32768, 32767, 1, 4095, 255, 0, 24'hFFFFFF);
    send_cell(0, 0);
    set_box(32767, -32768, 4095, 4095, 255, 256, 0);
    send_cell(0, 0);
    send_cell(2046, 0);
    send_cell(2047, 2047);
    send_cell(0, 2046);
    send_cell(1447, 1447);
    send_cell(1000, 1500);
    set_box(100, -200, 20, 30, 200, 128, 24'h123456);
    send_cell(0, 0);
    send_cell(9, 0);
    send_cell(10, 0);
    send_cell(0, 14);
    send_cell(0, 15);
    send_cell(7, 10);
    send_cell(5, 5);
    set_box(0, 0, 3, 3, 0, 511, 24'h00FF00);
    send_cell(0, 0);
    send_cell(1, 0);
  endtask

  // Random boxes, mostly small, cells mostly within the half axes
  task automatic test_random(int n);
    int w, h;
    logic [10:0] cx, cy;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(64);
        h = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(64);
        set_box($urandom, $urandom, w, h, $urandom_range(255), $urandom_range(511),
                $urandom);
      end
      if ($urandom_range(9) == 0) begin
        cx = $urandom;
        cy = $urandom;
      end else begin
        cx = $urandom_range((w >> 1) > 0 ? (w >> 1) : 0);
        cy = $urandom_range((h >> 1) > 0 ? (h >> 1) : 0);
      end
      send_cell(cx, cy);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.column_offset = '0;
    in_ch.row_offset = '0;
    err_count = 0;
    send_idle_pct = 28;
    recv_stall_pct = 58;
    sh_ox = 0; sh_oy = 0; sh_w = 0; sh_h = 0;
    sh_peak = 8'd255; sh_blur = 0; sh_color = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(150);
    drain();
    send_idle_pct = 58;
    recv_stall_pct = 28;
    test_random(150);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(150);
    drain();

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/sepe_pkg.sv
hdl/sepe_if.sv
hdl/sepe_front.sv
hdl/sepe_divider.sv
hdl/soft_edge_ellipse_pixel_eval.sv
sim/tb_soft_edge_ellipse_pixel_eval.sv
